@@ hdl/tsfc_pkg.sv @@
// Shared types, constants and register codes for the touch sample filter.
package tsfc_pkg;

  // Filter, scaling, screen and pressure constants
  localparam int FILTER_WEIGHT   = 3;
  localparam int X_SCALE_DIV     = 100;
  localparam int Y_SCALE_DIV     = 100;
  localparam int SCREEN_WIDTH    = 320;
  localparam int SCREEN_HEIGHT   = 240;
  localparam int PRESS_THRESHOLD = 3000;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Reciprocal for the raw-word scaling: exact floor division for 15-bit words
  localparam int SCALE_N       = 15;
  localparam int SCALE_RECIP_W = SCALE_N + 1;
  localparam int X_SHIFT       = SCALE_N + $clog2(X_SCALE_DIV);
  localparam int Y_SHIFT       = SCALE_N + $clog2(Y_SCALE_DIV);
  localparam logic [SCALE_RECIP_W-1:0] X_RECIP =
    SCALE_RECIP_W'(((longint'(1) << X_SHIFT) + X_SCALE_DIV - 1) / X_SCALE_DIV);
  localparam logic [SCALE_RECIP_W-1:0] Y_RECIP =
    SCALE_RECIP_W'(((longint'(1) << Y_SHIFT) + Y_SCALE_DIV - 1) / Y_SCALE_DIV);

  // Reciprocal for the running-average division by FILTER_WEIGHT + 1
  localparam int FOLD_N       = 24;
  localparam int FOLD_DIV     = FILTER_WEIGHT + 1;
  localparam int FOLD_SHIFT   = FOLD_N + $clog2(FOLD_DIV);
  localparam int FOLD_RECIP_W = FOLD_N + 1;
  localparam logic [FOLD_RECIP_W-1:0] FOLD_RECIP =
    FOLD_RECIP_W'(((longint'(1) << FOLD_SHIFT) + FOLD_DIV - 1) / FOLD_DIV);

  // Affine divider widths: numerator magnitude and divisor magnitude
  localparam int AFF_NUM_W = 48;
  localparam int AFF_DEN_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROTATION   = 3'd0,
    CFG_GAIN_XX    = 3'd1,
    CFG_GAIN_XY    = 3'd2,
    CFG_OFFSET_X   = 3'd3,
    CFG_GAIN_YX    = 3'd4,
    CFG_GAIN_YY    = 3'd5,
    CFG_OFFSET_Y   = 3'd6,
    CFG_DIVISOR    = 3'd7
  } cfg_reg_e;

  // Screen rotation modes
  typedef enum logic [1:0] {
    ROT_PORTRAIT      = 2'd0,
    ROT_LANDSCAPE     = 2'd1,
    ROT_PORTRAIT_REV  = 2'd2,
    ROT_LANDSCAPE_REV = 2'd3
  } rot_mode_e;

  // Front sequencer states
  typedef enum logic [1:0] {
    FE_IDLE  = 2'd0,
    FE_SCALE = 2'd1,
    FE_SUM   = 2'd2,
    FE_FOLD  = 2'd3
  } fe_state_e;

  // Back sequencer states
  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_MUL_X  = 3'd1,
    BK_MUL_Y  = 3'd2,
    BK_SUM    = 3'd3,
    BK_START  = 3'd4,
    BK_DIVIDE = 3'd5,
    BK_FINISH = 3'd6
  } bk_state_e;

  // Input item
  typedef struct packed {
    logic [14:0] x_word;
    logic [14:0] y_word;
    logic [7:0]  z1_level;
    logic [7:0]  z2_level;
    logic        first_pair;
    logic        last_pair;
  } tsfc_in_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] x_screen;
    logic signed [15:0] y_screen;
    logic signed [15:0] x_oriented;
    logic signed [15:0] y_oriented;
    logic               touched;
    logic               cal_invalid;
  } tsfc_out_t;

  // Snapshot handed from front to back at the end of a burst
  typedef struct packed {
    logic [15:0] x_avg;
    logic [15:0] y_avg;
    logic [7:0]  z1_level;
    logic [7:0]  z2_level;
  } tsfc_entry_t;

  // Configuration write
  typedef struct packed {
    logic                  valid;
    cfg_reg_e              index;
    logic [CFG_DATA_W-1:0] data;
  } tsfc_cfg_wr_t;

endpackage

@@ hdl/touch_sample_filter_calibrate.sv @@
// Top level of the touch sample filter with affine calibration.
// Each accepted item (one X/Y ADC pair) is scaled and folded into the running
// averages by the front end in the steps accept, scale, weighted sum and divide
// by reciprocal; full is high from each push until the fold is done. An item
// flagged last hands a snapshot to a 2-entry queue; the back end turns each
// snapshot into one result, using the 48-step bit-serial division of the affine
// numerators. While the back end works, the front end keeps taking items, but
// holds a burst end while the queue is full, and a finished result waits in an
// output register until popped. Configuration writes are taken every cycle.
module touch_sample_filter_calibrate
  import tsfc_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  tsfc_in_t               in_item_i,
  output logic                   empty,
  input  logic                   pop,
  output tsfc_out_t              out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic         q_push, q_pop, q_full, q_empty;
  tsfc_entry_t  q_wr_entry, q_rd_entry;
  tsfc_cfg_wr_t cfg_wr;

  // Accept configuration writes at any time
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  tsfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push && !full),
    .full_o    (full),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  tsfc_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tsfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_rd_entry),
    .q_pop_o    (q_pop),
    .pop_i      (pop && !empty),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

@@ hdl/tsfc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module tsfc_div
  import tsfc_pkg::*;
#(
  parameter int NUM_W = AFF_NUM_W,
  parameter int DEN_W = AFF_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_d;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial = {rem_q, quot_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Count the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quot_q <= num_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  // A new division never starts on top of a running one
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

@@ hdl/tsfc_queue.sv @@
// Small queue of burst snapshots between the front and the back.
module tsfc_queue
  import tsfc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tsfc_entry_t entry_i,
  input  logic        pop_i,
  output tsfc_entry_t entry_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsfc_entry_t      entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o = entries_q[rd_ptr_q];
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

@@ hdl/tsfc_front.sv @@
// Front end: accepts items, scales the raw words and updates the running averages.
module tsfc_front
  import tsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  tsfc_in_t    in_item_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output tsfc_entry_t q_entry_o
);

  localparam int SCALE_PROD_W = SCALE_N + SCALE_RECIP_W;
  localparam int FOLD_PROD_W  = FOLD_N + FOLD_RECIP_W;

  fe_state_e state_q, state_d;
  logic      load;
  logic      avg_upd;

  tsfc_in_t            item_q;
  logic [14:0]         xs_q, ys_q;
  logic [FOLD_N-1:0]   sum_x_q, sum_y_q;
  logic [15:0]         x_avg_q, y_avg_q;

  logic [SCALE_PROD_W-1:0] xs_prod, ys_prod;
  logic [15:0]             x_base, y_base;
  logic [FOLD_PROD_W-1:0]  x_fold_prod, y_fold_prod;
  logic [15:0]             x_avg_d, y_avg_d;

  // Sequence one item: accept, scale, weighted sum, divide
  always_comb begin
    state_d  = state_q;
    full_o   = 1'b1;
    load     = 1'b0;
    avg_upd  = 1'b0;
    q_push_o = 1'b0;
    case (state_q)
      FE_IDLE: begin
        full_o = 1'b0;
        if (push_i) begin
          load    = 1'b1;
          state_d = FE_SCALE;
        end
      end
      FE_SCALE: begin
        state_d = FE_SUM;
      end
      FE_SUM: begin
        state_d = FE_FOLD;
      end
      FE_FOLD: begin
        // hold a burst end until the queue has room
        if (!item_q.last_pair || !q_full_i) begin
          avg_upd  = 1'b1;
          q_push_o = item_q.last_pair;
          state_d  = FE_IDLE;
        end
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scale by reciprocal multiply, pick the previous average (zero on a first item) and divide the weighted sum
  always_comb begin
    xs_prod     = SCALE_PROD_W'(item_q.x_word) * SCALE_PROD_W'(X_RECIP);
    ys_prod     = SCALE_PROD_W'(item_q.y_word) * SCALE_PROD_W'(Y_RECIP);
    x_base      = item_q.first_pair ? '0 : x_avg_q;
    y_base      = item_q.first_pair ? '0 : y_avg_q;
    x_fold_prod = FOLD_PROD_W'(sum_x_q) * FOLD_PROD_W'(FOLD_RECIP);
    y_fold_prod = FOLD_PROD_W'(sum_y_q) * FOLD_PROD_W'(FOLD_RECIP);
    x_avg_d     = 16'(x_fold_prod >> FOLD_SHIFT);
    y_avg_d     = 16'(y_fold_prod >> FOLD_SHIFT);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
    if (state_q == FE_SCALE) begin
      xs_q <= 15'(xs_prod >> X_SHIFT);
      ys_q <= 15'(ys_prod >> Y_SHIFT);
    end
    if (state_q == FE_SUM) begin
      sum_x_q <= FOLD_N'(x_base) * FOLD_N'(FILTER_WEIGHT) + FOLD_N'(xs_q);
      sum_y_q <= FOLD_N'(y_base) * FOLD_N'(FILTER_WEIGHT) + FOLD_N'(ys_q);
    end
  end

  // Running averages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_avg_q <= '0;
      y_avg_q <= '0;
    end else if (avg_upd) begin
      x_avg_q <= x_avg_d;
      y_avg_q <= y_avg_d;
    end
  end

  // Snapshot for the back end carries the freshly folded averages
  always_comb begin
    q_entry_o.x_avg    = x_avg_d;
    q_entry_o.y_avg    = y_avg_d;
    q_entry_o.z1_level = item_q.z1_level;
    q_entry_o.z2_level = item_q.z2_level;
  end

endmodule

@@ hdl/tsfc_back.sv @@
// Back end: configuration registers, rotation, touch test, affine calibration, result register.
module tsfc_back
  import tsfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tsfc_cfg_wr_t cfg_wr_i,
  input  logic         q_empty_i,
  input  tsfc_entry_t  q_entry_i,
  output logic         q_pop_o,
  input  logic         pop_i,
  output logic         empty_o,
  output tsfc_out_t    out_item_o
);

  localparam logic signed [17:0] SCR_H  = 18'(SCREEN_HEIGHT);
  localparam logic signed [17:0] SCR_W  = 18'(SCREEN_WIDTH);
  localparam logic signed [24:0] THRESH = 25'(PRESS_THRESHOLD);

  // Configuration registers
  rot_mode_e          rot_q;
  logic signed [31:0] gain_xx_q, gain_xy_q, offset_x_q;
  logic signed [31:0] gain_yx_q, gain_yy_q, offset_y_q;
  logic signed [31:0] div_q;

  bk_state_e state_q, state_d;
  logic      ratio_start, aff_start, out_wr;
  logic      ratio_busy, aff_busy_x, aff_busy_y;

  logic signed [17:0] xa, ya, xo_raw, yo_raw;
  logic signed [15:0] xo_q, yo_q;
  logic signed [47:0] pa_x_q, pa_y_q, pb_x_q, pb_y_q;
  logic signed [48:0] num_x_q, num_y_q;
  logic               neg_x_q, neg_y_q;

  logic [AFF_NUM_W-1:0] num_x_mag, num_y_mag, quot_x, quot_y;
  logic [AFF_DEN_W-1:0] den_mag;
  logic [7:0]           ratio;
  logic signed [24:0]   touch_prod;
  logic                 invalid;

  tsfc_out_t out_q, res;
  logic      out_valid_q;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = 16'(v);
    end
  endfunction

  // Saturate a quotient given as magnitude and sign
  function automatic logic signed [15:0] sat_quot(input logic [AFF_NUM_W-1:0] mag,
                                                  input logic neg);
    if (neg) begin
      sat_quot = (mag > AFF_NUM_W'(32768)) ? 16'sh8000 : 16'(17'd0 - 17'(mag));
    end else begin
      sat_quot = (mag > AFF_NUM_W'(32767)) ? 16'sh7fff : 16'(mag);
    end
  endfunction

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q      <= ROT_PORTRAIT;
      gain_xx_q  <= 32'sd1;
      gain_xy_q  <= 32'sd0;
      offset_x_q <= 32'sd0;
      gain_yx_q  <= 32'sd0;
      gain_yy_q  <= 32'sd1;
      offset_y_q <= 32'sd0;
      div_q      <= 32'sd1;
    end else if (cfg_wr_i.valid) begin
      case (cfg_wr_i.index)
        CFG_ROTATION: rot_q      <= rot_mode_e'(cfg_wr_i.data[1:0]);
        CFG_GAIN_XX:  gain_xx_q  <= cfg_wr_i.data;
        CFG_GAIN_XY:  gain_xy_q  <= cfg_wr_i.data;
        CFG_OFFSET_X: offset_x_q <= cfg_wr_i.data;
        CFG_GAIN_YX:  gain_yx_q  <= cfg_wr_i.data;
        CFG_GAIN_YY:  gain_yy_q  <= cfg_wr_i.data;
        CFG_OFFSET_Y: offset_y_q <= cfg_wr_i.data;
        CFG_DIVISOR:  div_q      <= cfg_wr_i.data;
        default: ;
      endcase
    end
  end

  // Sequence one burst result
  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    ratio_start = 1'b0;
    aff_start   = 1'b0;
    out_wr      = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          ratio_start = 1'b1;
          state_d     = BK_MUL_X;
        end
      end
      BK_MUL_X:  state_d = BK_MUL_Y;
      BK_MUL_Y:  state_d = BK_SUM;
      BK_SUM:    state_d = BK_START;
      BK_START: begin
        aff_start = 1'b1;
        state_d   = BK_DIVIDE;
      end
      BK_DIVIDE: begin
        if (!aff_busy_x) begin
          state_d = BK_FINISH;
        end
      end
      BK_FINISH: begin
        // hold until the result register is free
        if (!out_valid_q || pop_i) begin
          out_wr  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Rotate the averages at the queue head
  always_comb begin
    xa = 18'($signed({2'b00, q_entry_i.x_avg}));
    ya = 18'($signed({2'b00, q_entry_i.y_avg}));
    case (rot_q)
      ROT_PORTRAIT: begin
        xo_raw = SCR_H - xa;
        yo_raw = ya;
      end
      ROT_LANDSCAPE: begin
        xo_raw = ya;
        yo_raw = xa;
      end
      ROT_PORTRAIT_REV: begin
        xo_raw = xa;
        yo_raw = SCR_W - ya;
      end
      ROT_LANDSCAPE_REV: begin
        xo_raw = SCR_W - ya;
        yo_raw = SCR_H - xa;
      end
      default: begin
        xo_raw = xa;
        yo_raw = ya;
      end
    endcase
  end

  // Affine datapath: saturated oriented point, products, sums, signs
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        xo_q <= sat16(xo_raw);
        yo_q <= sat16(yo_raw);
      end
      BK_MUL_X: begin
        pa_x_q <= 48'(gain_xx_q) * 48'(xo_q);
        pa_y_q <= 48'(gain_yx_q) * 48'(xo_q);
      end
      BK_MUL_Y: begin
        pb_x_q <= 48'(gain_xy_q) * 48'(yo_q);
        pb_y_q <= 48'(gain_yy_q) * 48'(yo_q);
      end
      BK_SUM: begin
        num_x_q <= 49'(pa_x_q) + 49'(pb_x_q) + 49'(offset_x_q);
        num_y_q <= 49'(pa_y_q) + 49'(pb_y_q) + 49'(offset_y_q);
      end
      BK_START: begin
        neg_x_q <= num_x_q[48] ^ div_q[31];
        neg_y_q <= num_y_q[48] ^ div_q[31];
      end
      default: ;
    endcase
  end

  // Magnitudes for the unsigned dividers
  always_comb begin
    num_x_mag = num_x_q[48] ? AFF_NUM_W'(-num_x_q) : AFF_NUM_W'(num_x_q);
    num_y_mag = num_y_q[48] ? AFF_NUM_W'(-num_y_q) : AFF_NUM_W'(num_y_q);
    den_mag   = div_q[31] ? AFF_DEN_W'(-div_q) : AFF_DEN_W'(div_q);
  end

  // Pressure ratio z2 / (z1 + 1)
  tsfc_div #(
    .NUM_W (8),
    .DEN_W (9)
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ratio_start),
    .num_i   (q_entry_i.z2_level),
    .den_i   (9'(q_entry_i.z1_level) + 9'd1),
    .busy_o  (ratio_busy),
    .quot_o  (ratio)
  );

  tsfc_div #(
    .NUM_W (AFF_NUM_W),
    .DEN_W (AFF_DEN_W)
  ) u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aff_start),
    .num_i   (num_x_mag),
    .den_i   (den_mag),
    .busy_o  (aff_busy_x),
    .quot_o  (quot_x)
  );

  tsfc_div #(
    .NUM_W (AFF_NUM_W),
    .DEN_W (AFF_DEN_W)
  ) u_y_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aff_start),
    .num_i   (num_y_mag),
    .den_i   (den_mag),
    .busy_o  (aff_busy_y),
    .quot_o  (quot_y)
  );

  // Form the result: touch test, saturation, zero-divisor flag
  always_comb begin
    touch_prod     = 25'(yo_q) * 25'($signed({1'b0, ratio}));
    invalid        = (div_q == '0);
    res.x_screen   = invalid ? '0 : sat_quot(quot_x, neg_x_q);
    res.y_screen   = invalid ? '0 : sat_quot(quot_y, neg_y_q);
    res.x_oriented = xo_q;
    res.y_oriented = yo_q;
    res.touched    = (touch_prod < THRESH);
    res.cal_invalid = invalid;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_wr) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_q <= res;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  a_ratio_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FINISH) |-> !ratio_busy)
    else $error("pressure ratio not ready at result time");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIVIDE) |-> (aff_busy_x == aff_busy_y))
    else $error("affine dividers out of step");

endmodule

@@ tb/tsfc_checker.sv @@
// Checker for the touch sample filter: tracks averages and registers, predicts and compares.
module tsfc_checker
  import tsfc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   full_i,
  input  tsfc_in_t               in_item_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  tsfc_out_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatch_count_o,
  output int                     points_waiting_o
);

  // Shadow copy of the register file
  rot_mode_e          rot_mode;
  logic signed [31:0] gain_xx, gain_xy, offset_x;
  logic signed [31:0] gain_yx, gain_yy, offset_y;
  logic signed [31:0] divisor;

  // Running averages, unrotated
  logic [15:0] x_avg, y_avg;

  tsfc_out_t expected_points[$];
  int        n_mismatch;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Scale the raw word and fold it into the average with truncating division
  function automatic logic [15:0] fold_avg(logic [15:0] avg, logic [14:0] word, int scale);
    longint sample;
    sample = longint'(word) / scale;
    return 16'((longint'(avg) * FILTER_WEIGHT + sample) / (FILTER_WEIGHT + 1));
  endfunction

  // Exact affine sum, truncating division, then saturation
  function automatic longint calibrate(logic signed [31:0] ga, logic signed [31:0] gb,
                                       logic signed [31:0] off, longint xo, longint yo);
    longint num;
    num = longint'(ga) * xo + longint'(gb) * yo + longint'(off);
    return sat16(num / longint'(divisor));
  endfunction

  task automatic report(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    n_mismatch++;
  endtask

  task automatic compare_field(string name, longint got, longint want);
    if (got != want)
      report($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Update averages for one accepted item and queue the point it ends, if any
  task automatic predict_pair(tsfc_in_t it);
    longint    xa, ya, xo, yo, ratio;
    tsfc_out_t pt;
    if (it.first_pair) begin
      x_avg = '0;
      y_avg = '0;
    end
    x_avg = fold_avg(x_avg, it.x_word, X_SCALE_DIV);
    y_avg = fold_avg(y_avg, it.y_word, Y_SCALE_DIV);
    if (it.last_pair) begin
      xa = longint'(x_avg);
      ya = longint'(y_avg);
      case (rot_mode)
        ROT_PORTRAIT: begin
          xo = SCREEN_HEIGHT - xa;
          yo = ya;
        end
        ROT_LANDSCAPE: begin
          xo = ya;
          yo = xa;
        end
        ROT_PORTRAIT_REV: begin
          xo = xa;
          yo = SCREEN_WIDTH - ya;
        end
        default: begin
          xo = SCREEN_WIDTH - ya;
          yo = SCREEN_HEIGHT - xa;
        end
      endcase
      xo = sat16(xo);
      yo = sat16(yo);
      ratio = longint'(it.z2_level) / (longint'(it.z1_level) + 1);
      pt.x_oriented = 16'(xo);
      pt.y_oriented = 16'(yo);
      pt.touched    = (yo * ratio < PRESS_THRESHOLD);
      if (divisor == 0) begin
        pt.cal_invalid = 1'b1;
        pt.x_screen    = '0;
        pt.y_screen    = '0;
      end else begin
        pt.cal_invalid = 1'b0;
        pt.x_screen    = 16'(calibrate(gain_xx, gain_xy, offset_x, xo, yo));
        pt.y_screen    = 16'(calibrate(gain_yx, gain_yy, offset_y, xo, yo));
      end
      expected_points.push_back(pt);
    end
  endtask

  // Watch all three channels on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    tsfc_out_t want;
    if (!rst_ni) begin
      rot_mode   = ROT_PORTRAIT;
      gain_xx    = 1;
      gain_xy    = 0;
      offset_x   = 0;
      gain_yx    = 0;
      gain_yy    = 1;
      offset_y   = 0;
      divisor    = 1;
      x_avg      = '0;
      y_avg      = '0;
      n_mismatch = 0;
      expected_points.delete();
    end else begin
      // Apply register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_ROTATION: rot_mode = rot_mode_e'(cfg_data_i[1:0]);
          CFG_GAIN_XX:  gain_xx  = cfg_data_i;
          CFG_GAIN_XY:  gain_xy  = cfg_data_i;
          CFG_OFFSET_X: offset_x = cfg_data_i;
          CFG_GAIN_YX:  gain_yx  = cfg_data_i;
          CFG_GAIN_YY:  gain_yy  = cfg_data_i;
          CFG_OFFSET_Y: offset_y = cfg_data_i;
          CFG_DIVISOR:  divisor  = cfg_data_i;
          default: ;
        endcase
      end
      // Compare the popped point with the oldest prediction
      if (pop_i && !empty_i) begin
        if (expected_points.size() == 0) begin
          report("result popped with no item expected");
        end else begin
          want = expected_points.pop_front();
          compare_field("x_screen", out_item_i.x_screen, want.x_screen);
          compare_field("y_screen", out_item_i.y_screen, want.y_screen);
          compare_field("x_oriented", out_item_i.x_oriented, want.x_oriented);
          compare_field("y_oriented", out_item_i.y_oriented, want.y_oriented);
          compare_field("touched", out_item_i.touched, want.touched);
          compare_field("cal_invalid", out_item_i.cal_invalid, want.cal_invalid);
        end
      end
      if (push_i && !full_i)
        predict_pair(in_item_i);
    end
    mismatch_count_o <= n_mismatch;
    points_waiting_o <= expected_points.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, stimulus, result draining and the final verdict.
module tb_top
  import tsfc_pkg::*;
;

  localparam int STALL_LIMIT = 3000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  tsfc_in_t               in_item;
  logic                   empty;
  logic                   pop;
  tsfc_out_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int points_waiting;
  int stall_cycles;
  bit quiet;

  touch_sample_filter_calibrate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tsfc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .in_item_i        (in_item),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_item_i       (out_item),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .points_waiting_o (points_waiting)
  );

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Abort when nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: pop with random stall bursts
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  function automatic tsfc_in_t make_pair(int x, int y, int z1, int z2, bit first, bit last);
    tsfc_in_t p;
    p.x_word     = 15'(x);
    p.y_word     = 15'(y);
    p.z1_level   = 8'(z1);
    p.z2_level   = 8'(z2);
    p.first_pair = first;
    p.last_pair  = last;
    return p;
  endfunction

  function automatic int pick_word();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 32767;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Pressure readings lean toward a small z1 so both touch outcomes show up
  function automatic tsfc_in_t random_pair(bit first, bit last);
    int z1;
    z1 = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    return make_pair(pick_word(), pick_word(), z1, $urandom_range(0, 255), first, last);
  endfunction

  function automatic logic [31:0] random_gain();
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 16)) - 8;
      1:       return int'($urandom_range(0, 2000)) - 1000;
      2:       return ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_divisor();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1, 2, 3: return int'($urandom_range(1, 16)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
      4:       return int'($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Send one item, optionally after an idle burst; push stays high afterwards
  task automatic send_pair(tsfc_in_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
  endtask

  // Hold off until every predicted point has been popped and the front end settles
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (points_waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_regs(rot_mode_e rot, logic [31:0] gxx, logic [31:0] gxy,
                              logic [31:0] ox, logic [31:0] gyx, logic [31:0] gyy,
                              logic [31:0] oy, logic [31:0] dv);
    write_reg(CFG_ROTATION, 32'(rot));
    write_reg(CFG_GAIN_XX, gxx);
    write_reg(CFG_GAIN_XY, gxy);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_GAIN_YX, gyx);
    write_reg(CFG_GAIN_YY, gyy);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_DIVISOR, dv);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int sent;
    int len;
    bit noise;
    quiet      = 1'b0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extremes of the words and pressures, bursts with and without first
    send_pair(make_pair(0, 0, 0, 0, 1, 1));
    send_pair(make_pair(32767, 32767, 0, 255, 1, 1));
    send_pair(make_pair(32767, 0, 17, 200, 1, 0));
    send_pair(make_pair(12345, 32767, 0, 0, 0, 0));
    send_pair(make_pair(500, 9999, 255, 0, 0, 1));
    send_pair(make_pair(0, 0, 1, 255, 0, 1));
    drain();

    // Each remaining rotation with small gains
    program_regs(ROT_LANDSCAPE, 1, 0, 0, 0, 1, 0, 1);
    send_pair(make_pair(32767, 12000, 0, 255, 1, 1));
    send_pair(make_pair(100, 32767, 3, 90, 0, 1));
    drain();
    program_regs(ROT_PORTRAIT_REV, -3, 2, 100, 7, -5, -50, 3);
    send_pair(make_pair(20000, 32767, 0, 40, 1, 1));
    send_pair(make_pair(0, 0, 2, 255, 0, 1));
    drain();
    program_regs(ROT_LANDSCAPE_REV, -3, 2, 100, 7, -5, -50, -7);
    send_pair(make_pair(32767, 32767, 0, 255, 1, 1));
    send_pair(make_pair(32767, 0, 0, 30, 1, 1));
    drain();

    // Zero divisor flags the point and zeroes the screen values
    program_regs(ROT_PORTRAIT, 5, 5, 5, 5, 5, 5, 0);
    send_pair(make_pair(4000, 8000, 0, 10, 1, 1));
    send_pair(make_pair(32767, 32767, 9, 99, 0, 1));
    drain();

    // Extreme gains and offsets drive the screen values into saturation
    program_regs(ROT_LANDSCAPE_REV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_pair(make_pair(32767, 32767, 0, 255, 1, 1));
    send_pair(make_pair(0, 0, 0, 0, 1, 1));
    drain();
    program_regs(ROT_PORTRAIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_pair(make_pair(32767, 16000, 4, 200, 1, 1));
    drain();
    program_regs(ROT_LANDSCAPE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_pair(make_pair(21000, 32767, 0, 128, 1, 1));

    // Random phases: mostly well-formed bursts, some stray flags; the last runs without idling
    for (int phase = 0; phase < 9; phase++) begin
      drain();
      program_regs(rot_mode_e'($urandom_range(0, 3)), random_gain(), random_gain(),
                   random_gain(), random_gain(), random_gain(), random_gain(),
                   random_divisor());
      if (phase == 8) quiet = 1'b1;
      sent = 0;
      while (sent < 42) begin
        noise = ($urandom_range(0, 6) == 0);
        if (noise) begin
          send_pair(random_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            send_pair(random_pair(i == 0, i == len - 1));
            sent++;
          end
        end
      end
    end

    // Let the last points come out, then allow for any stray result
    drain();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
